### rtl/core/hbs_pkg.sv
// Shared types and constants for the hierarchical bitmap set.
// Used by hbs_scan and hierarchical_bitmap_set; depends on nothing.

package hbs_pkg;

    // Tree geometry: one summary word over 64 leaf words of 64 bits
    localparam int WORD_BITS  = 64;
    localparam int LEAF_WORDS = 64;
    localparam int BIT_W      = 6;
    localparam int KEY_W      = 12;
    localparam int SIZE_W     = 13;
    localparam int OP_W       = 3;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_ERASE  = 3'd1;
    localparam logic [OP_W-1:0] OP_TEST   = 3'd2;
    localparam logic [OP_W-1:0] OP_NEXT   = 3'd3;
    localparam logic [OP_W-1:0] OP_PREV   = 3'd4;

    // Outcome of one bit scan
    typedef struct packed {
        logic             any;
        logic [BIT_W-1:0] pos;
    } scan_t;

endpackage

### rtl/core/hierarchical_bitmap_set.sv
// Top level of the hierarchical bitmap set: sequencer, summary word, valid bits.
// Depends on hbs_pkg, hbs_ram and hbs_scan.

// Integer set of keys 0..4095 kept as 64 leaf words under one summary word.
// An item (op, key) is taken when start is high and busy is low; its single
// result appears on found/result_key/status for exactly one cycle with done
// high and must be captured then, since the block cannot be stalled. done
// rises after the S_LEAF step for insert, erase, test, unused op codes and
// a next or prev settled in the key's own leaf word; after the S_SUM step
// when next or prev finds no candidate word in the summary; after the S_DESC
// step when the search climbs to the summary word and descends to another
// leaf. A new item can be accepted in the cycle that done is shown. The
// steps follow from the registered read of the leaf memory and from the one
// scan unit that serves both levels.
// The leaf memory needs no clearing pass after reset: per-word valid bits
// make unwritten words read as empty. size_reg is written through the
// cfg port, which is ready whenever the block is idle and start is low.

module hierarchical_bitmap_set (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [hbs_pkg::OP_W-1:0]    op,
    input  logic [hbs_pkg::KEY_W-1:0]   key,
    output logic                        done,
    output logic                        found,
    output logic [hbs_pkg::KEY_W-1:0]   result_key,
    output logic                        status,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [hbs_pkg::SIZE_W-1:0]  cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LEAF,
        S_SUM,
        S_DESC
    } state_t;

    localparam int WORD_BITS  = hbs_pkg::WORD_BITS;
    localparam int LEAF_WORDS = hbs_pkg::LEAF_WORDS;
    localparam int BW = hbs_pkg::BIT_W;
    localparam int KW = hbs_pkg::KEY_W;
    localparam int SW = hbs_pkg::SIZE_W;

    state_t                  state_reg, state_next;
    logic [hbs_pkg::OP_W-1:0] op_reg, op_next;
    logic [KW-1:0]           key_reg, key_next;
    logic [SW-1:0]           size_reg, size_next;
    logic [WORD_BITS-1:0]    summary_reg, summary_next;
    logic [LEAF_WORDS-1:0]   valid_reg, valid_next;
    logic                    rvalid_reg;
    logic [BW-1:0]           desc_reg, desc_next;
    logic                    done_reg, done_next;
    logic                    found_reg, found_next;
    logic [KW-1:0]           rkey_reg, rkey_next;
    logic                    status_reg, status_next;

    // Memory and scan unit hookup
    logic                    we;
    logic [BW-1:0]           waddr;
    logic [WORD_BITS-1:0]    wdata;
    logic [BW-1:0]           raddr;
    logic [WORD_BITS-1:0]    rdata;
    logic [WORD_BITS-1:0]    leaf_word;
    logic [WORD_BITS-1:0]    scan_word;
    logic                    scan_high;
    hbs_pkg::scan_t          scan_res;

    // Item fields split into word index and bit index
    logic [BW-1:0]           w_idx;
    logic [BW-1:0]           b_idx;
    logic                    in_range;
    logic [WORD_BITS-1:0]    bit_mask;
    logic [WORD_BITS-1:0]    leaf_mask;
    logic [WORD_BITS-1:0]    sum_mask;
    logic [WORD_BITS-1:0]    new_word;
    logic [KW-1:0]           cand_key;
    logic                    cand_ok;
    logic                    accept;

    hbs_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (LEAF_WORDS)
    ) u_leaf_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    hbs_scan u_scan (
        .word       (scan_word),
        .high_first (scan_high),
        .res        (scan_res)
    );

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = ~busy & ~start;
    assign accept    = start & ~busy;

    assign w_idx     = key_reg[KW-1:BW];
    assign b_idx     = key_reg[BW-1:0];
    assign in_range  = ({1'b0, key_reg} < size_reg);
    assign leaf_word = rvalid_reg ? rdata : '0;
    assign bit_mask  = WORD_BITS'(1) << b_idx;
    assign scan_high = (op_reg == hbs_pkg::OP_PREV);

    // Leaf mask: bits at or above the key for next, at or below for prev
    assign leaf_mask = scan_high ? ({WORD_BITS{1'b1}} >> (~b_idx))
                                 : ({WORD_BITS{1'b1}} << b_idx);
    // Summary mask: words strictly above or strictly below the key's word
    assign sum_mask  = scan_high ? ~({WORD_BITS{1'b1}} << w_idx)
                                 : (({WORD_BITS{1'b1}} << w_idx) << 1);

    // Scan input per step
    always_comb
    begin
        case (state_reg)
            S_LEAF:  scan_word = leaf_word & leaf_mask;
            S_SUM:   scan_word = summary_reg & sum_mask;
            default: scan_word = leaf_word;
        endcase
    end

    // Candidate key from the scan; next must still fall below the limit
    assign cand_key = (state_reg == S_DESC) ? {desc_reg, scan_res.pos}
                                            : {w_idx, scan_res.pos};
    assign cand_ok  = scan_res.any & (scan_high | ({1'b0, cand_key} < size_reg));

    assign new_word = (op_reg == hbs_pkg::OP_INSERT) ? (leaf_word | bit_mask)
                                                     : (leaf_word & ~bit_mask);

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        size_next    = size_reg;
        summary_next = summary_reg;
        valid_next   = valid_reg;
        desc_next    = desc_reg;
        done_next    = 1'b0;
        found_next   = 1'b0;
        rkey_next    = '0;
        status_next  = 1'b0;
        we           = 1'b0;
        waddr        = w_idx;
        wdata        = new_word;
        raddr        = w_idx;

        if (cfg_valid && cfg_ready)
        begin
            size_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                raddr = key[KW-1:BW];
                if (accept)
                begin
                    op_next    = op;
                    key_next   = key;
                    state_next = S_LEAF;
                    // prev searches from the key clamped to the last valid key
                    if (op == hbs_pkg::OP_PREV && !({1'b0, key} < size_reg))
                    begin
                        key_next = KW'(size_reg - SW'(1));
                        raddr    = key_next[KW-1:BW];
                    end
                end
            end

            S_LEAF:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                case (op_reg)
                    hbs_pkg::OP_INSERT,
                    hbs_pkg::OP_ERASE:
                    begin
                        if (!in_range)
                        begin
                            status_next = 1'b1;
                        end
                        else
                        begin
                            we                = 1'b1;
                            valid_next[w_idx] = 1'b1;
                            summary_next[w_idx] = |new_word;
                        end
                    end
                    hbs_pkg::OP_TEST:
                    begin
                        found_next = in_range & leaf_word[b_idx];
                    end
                    hbs_pkg::OP_NEXT,
                    hbs_pkg::OP_PREV:
                    begin
                        if ((op_reg == hbs_pkg::OP_NEXT && !in_range) ||
                            (op_reg == hbs_pkg::OP_PREV && size_reg == '0))
                        begin
                            found_next = 1'b0;
                        end
                        else if (scan_res.any)
                        begin
                            found_next = cand_ok;
                            rkey_next  = cand_ok ? cand_key : '0;
                        end
                        else
                        begin
                            done_next  = 1'b0;
                            state_next = S_SUM;
                        end
                    end
                    default:
                    begin
                        found_next = 1'b0;
                    end
                endcase
            end

            S_SUM:
            begin
                // Pick the nearest non-empty word and fetch it
                raddr = scan_res.pos;
                if (scan_res.any)
                begin
                    desc_next  = scan_res.pos;
                    state_next = S_DESC;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_DESC:
            begin
                done_next  = 1'b1;
                found_next = cand_ok;
                rkey_next  = cand_ok ? cand_key : '0;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, store bookkeeping and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            size_reg    <= hbs_pkg::SIZE_RESET;
            summary_reg <= '0;
            valid_reg   <= '0;
            rvalid_reg  <= 1'b0;
            done_reg    <= 1'b0;
            found_reg   <= 1'b0;
            rkey_reg    <= '0;
            status_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            size_reg    <= size_next;
            summary_reg <= summary_next;
            valid_reg   <= valid_next;
            rvalid_reg  <= valid_reg[raddr];
            done_reg    <= done_next;
            found_reg   <= found_next;
            rkey_reg    <= rkey_next;
            status_reg  <= status_next;
        end
    end

    // Item payload registers
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        key_reg  <= key_next;
        desc_reg <= desc_next;
    end

    assign done       = done_reg;
    assign found      = found_reg;
    assign result_key = rkey_reg;
    assign status     = status_reg;

endmodule

### rtl/core/hbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module hbs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/hbs_scan.sv
// Shared bit scan unit: position of the lowest or highest set bit of a word.
// Depends on hbs_pkg.

module hbs_scan (
    input  logic [hbs_pkg::WORD_BITS-1:0] word,
    input  logic                          high_first,
    output hbs_pkg::scan_t                res
);

    logic [hbs_pkg::WORD_BITS-1:0] x;
    logic [hbs_pkg::WORD_BITS-1:0] iso;
    logic [hbs_pkg::BIT_W-1:0]     low_pos;

    // Mirror the word so that the highest bit becomes the lowest
    always_comb
    begin
        for (int i = 0; i < hbs_pkg::WORD_BITS; i++)
        begin
            x[i] = high_first ? word[hbs_pkg::WORD_BITS-1-i] : word[i];
        end
    end

    // Isolate the lowest set bit
    assign iso = x & (~x + hbs_pkg::WORD_BITS'(1));

    // One-hot to binary
    always_comb
    begin
        low_pos = '0;
        for (int i = 0; i < hbs_pkg::WORD_BITS; i++)
        begin
            if (iso[i])
            begin
                low_pos = low_pos | hbs_pkg::BIT_W'(i);
            end
        end
    end

    assign res.any = |word;
    assign res.pos = high_first ? ~low_pos : low_pos;

endmodule
